[rtl/czs_pkg.sv]
package czs_pkg;

  localparam int SampleW         = 16;
  localparam int SumW            = 22;
  localparam int SqSumW          = 38;
  localparam int ZW              = 16;
  localparam int QuotBits        = 35;
  localparam int RootSteps       = 18;
  localparam int KW              = 18;
  localparam int StepCntW        = 6;
  localparam int DefMaxRows      = 64;
  localparam int DefFractionBits = 12;

  localparam logic [KW-1:0] ZMaxMag = KW'(32767);
  localparam logic [KW-1:0] ZMinMag = KW'(32768);

  typedef struct packed {
    logic signed [SampleW-1:0] sample_value;
    logic                      last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [ZW-1:0] zscore;
    logic                 last_result;
    logic                 degenerate;
    logic                 saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_COL1,
    ST_COL2,
    ST_COL3,
    ST_READ,
    ST_DIFF,
    ST_SQUARE,
    ST_SCALE,
    ST_CHECK,
    ST_DIVIDE,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_FINISH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic take;
    logic col1;
    logic col2;
    logic col3;
    logic read;
    logic diff;
    logic square;
    logic scale;
    logic check;
    logic div_step;
    logic root_init;
    logic root_step;
    logic finish;
    logic next_idx;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic degen;
    logic idx_last;
  } status_t;

endpackage

[rtl/column_zscore_standardizer.sv]
// channel   direction  handshake               payload
// input     in         in_valid_i / in_stall_o  in_item_i  (sample_value, last_sample)
// output    out        out_valid_o / out_stall_i out_item_o (zscore, last_result,
//                                                           degenerate, saturated)
//
// loading accepts each valid sample; setup after the last sample runs COL1, COL2 and COL3
// each result then passes through memory read, difference, square, scale, the serial divider,
// the square root unit and output; degenerate results go straight to output
// reset clears the state machine and the column accumulators; the sample memory is not cleared
// in_stall_o is high from the last sample of a column until its final result is taken
// a stall on the output holds the result register and freezes the block

module column_zscore_standardizer import czs_pkg::*; #(
  parameter int MAX_ROWS      = DefMaxRows,
  parameter int FRACTION_BITS = DefFractionBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // command and status between controller and datapath
  cmd_t    cmd;
  status_t status;

  // controller: sequences load, column setup, and per-sample divide and root
  czs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (in_item_i.last_sample),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // datapath: sample memory, accumulators, divider, square root, output register
  czs_datapath #(
    .MAX_ROWS      (MAX_ROWS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

  // loading and emitting never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_stall_o |-> !out_valid_o)
    else $error("input taken while a result is shown");

  // degenerate results are zero and never clipped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.degenerate) |->
      (out_item_o.zscore == '0) && !out_item_o.saturated)
    else $error("degenerate result not zero");

  // a clipped result sits at one of the range limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.saturated) |->
      ((out_item_o.zscore == ZW'(ZMaxMag)) || (out_item_o.zscore == ZW'(ZMinMag))))
    else $error("saturated result not at a limit");

endmodule

[rtl/czs_ctrl.sv]
module czs_ctrl import czs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    last_i,
  input  logic    out_stall_i,
  input  status_t status_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  output cmd_t    cmd_o
);

  state_e              state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (last_i) state_d = ST_COL1;
        end
      end
      ST_COL1: begin
        cmd_o.col1 = 1'b1;
        state_d    = ST_COL2;
      end
      ST_COL2: begin
        cmd_o.col2 = 1'b1;
        state_d    = ST_COL3;
      end
      ST_COL3: begin
        cmd_o.col3 = 1'b1;
        state_d    = status_i.degen ? ST_FINISH : ST_READ;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        cnt_d       = StepCntW'(QuotBits - 1);
        state_d     = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) state_d = ST_ROOT_INIT;
        else cnt_d = cnt_q - 1'b1;
      end
      ST_ROOT_INIT: begin
        cmd_o.root_init = 1'b1;
        cnt_d           = StepCntW'(RootSteps - 1);
        state_d         = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == '0) state_d = ST_FINISH;
        else cnt_d = cnt_q - 1'b1;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          if (status_i.idx_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end else begin
            cmd_o.next_idx = 1'b1;
            state_d        = status_i.degen ? ST_FINISH : ST_READ;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = (state_q == ST_EMIT);

endmodule

[rtl/czs_datapath.sv]
module czs_datapath import czs_pkg::*; #(
  parameter int MAX_ROWS      = DefMaxRows,
  parameter int FRACTION_BITS = DefFractionBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  in_item_t  in_item_i,
  output status_t   status_o,
  output out_item_t out_item_o
);

  localparam int CntW  = $clog2(MAX_ROWS + 1);
  localparam int IdxW  = $clog2(MAX_ROWS);
  localparam int NsqW  = CntW + SqSumW;
  localparam int QW    = ((NsqW > 2 * SumW) ? NsqW : 2 * SumW) + 1;
  localparam int NqW   = CntW + QW - 1;
  localparam int NxW   = CntW + SampleW + 1;
  localparam int DW    = ((NxW > SumW) ? NxW : SumW) + 1;
  localparam int AdW   = DW - 1;
  localparam int D2W   = 2 * AdW;
  localparam int PrW   = D2W + CntW;
  localparam int ShW   = 2 + 2 * FRACTION_BITS;
  localparam int RW    = PrW + ShW;
  localparam int WA    = NqW + QuotBits;
  localparam int WW    = (RW > WA) ? RW : WA;
  localparam int RootW = QuotBits + 1;

  // column accumulators
  logic [CntW-1:0]          count_q;
  logic signed [SumW-1:0]   sum_q;
  logic [SqSumW-1:0]        sqsum_q;
  logic [IdxW-1:0]          idx_q;

  logic signed [SampleW-1:0] mem [MAX_ROWS];
  logic signed [SampleW-1:0] rd_q;

  logic [NsqW-1:0]     nsq_q;
  logic [2*SumW-1:0]   ss_q;
  logic [QW-2:0]       qpos_q;
  logic                degen_q;
  logic [NqW-1:0]      nq_q;
  logic                neg_q;
  logic [AdW-1:0]      ad_q;
  logic [D2W-1:0]      d2_q;
  logic [RW-1:0]       r_q;
  logic                big_q;
  logic [WW-1:0]       rem_q;
  logic [WW-1:0]       dvs_q;
  logic [QuotBits-1:0] qt_q;
  logic [QuotBits-1:0] rt_rem_q;
  logic [RootW-1:0]    rt_res_q;
  logic [RootW-1:0]    rt_bit_q;
  out_item_t           out_q;

  logic                       room_c;
  logic signed [2*SampleW-1:0] xx_c;
  logic signed [QW-1:0]       q_c;
  logic signed [NxW-1:0]      nx_c;
  logic signed [DW-1:0]       d_c;
  logic [DW-1:0]              dmag_c;
  logic [CntW-1:0]            nm1_c;
  logic [PrW-1:0]             prod_c;
  logic [RootW-1:0]           trial_c;
  logic [RootW-1:0]           kfull_c;
  logic [KW-1:0]              k_c;
  logic [KW-1:0]              kneg_c;
  logic                       idx_last_c;

  assign room_c     = (count_q < CntW'(MAX_ROWS));
  assign xx_c       = (2*SampleW)'(in_item_i.sample_value) *
                      (2*SampleW)'(in_item_i.sample_value);
  assign q_c        = $signed(QW'(nsq_q)) - $signed(QW'(ss_q));
  assign nx_c       = NxW'($signed({1'b0, count_q})) * NxW'(rd_q);
  assign d_c        = DW'(nx_c) - DW'(sum_q);
  assign dmag_c     = d_c[DW-1] ? DW'(-d_c) : DW'(d_c);
  assign nm1_c      = count_q - 1'b1;
  assign prod_c     = PrW'(d2_q) * PrW'(nm1_c);
  assign trial_c    = rt_res_q + rt_bit_q;
  assign kfull_c    = (rt_res_q + RootW'(1)) >> 1;
  assign k_c        = kfull_c[KW-1:0];
  assign kneg_c     = ~k_c + 1'b1;
  assign idx_last_c = ((CntW'(idx_q) + 1'b1) == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sqsum_q <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
        sum_q   <= '0;
        sqsum_q <= '0;
        idx_q   <= '0;
      end else if (cmd_i.take && room_c) begin
        count_q <= count_q + 1'b1;
        sum_q   <= sum_q + SumW'(in_item_i.sample_value);
        sqsum_q <= sqsum_q + SqSumW'($unsigned(xx_c));
      end
      if (cmd_i.col1) idx_q <= '0;
      else if (cmd_i.next_idx) idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && room_c) mem[count_q[IdxW-1:0]] <= in_item_i.sample_value;
    if (cmd_i.read) rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.col1) begin
      nsq_q <= NsqW'(count_q) * NsqW'(sqsum_q);
      ss_q  <= (2*SumW)'(sum_q) * (2*SumW)'(sum_q);
    end
    if (cmd_i.col2) begin
      qpos_q  <= q_c[QW-2:0];
      degen_q <= (count_q < CntW'(2)) || (q_c <= 0);
    end
    if (cmd_i.col3) nq_q <= NqW'(count_q) * NqW'(qpos_q);
    if (cmd_i.diff) begin
      neg_q <= d_c[DW-1];
      ad_q  <= dmag_c[AdW-1:0];
    end
    if (cmd_i.square) d2_q <= D2W'(ad_q) * D2W'(ad_q);
    if (cmd_i.scale) r_q <= {prod_c, {ShW{1'b0}}};
    if (cmd_i.check) begin
      big_q <= (WW'(r_q >> QuotBits) >= WW'(nq_q));
      rem_q <= WW'(r_q);
      dvs_q <= WW'(nq_q) << (QuotBits - 1);
      qt_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= dvs_q) begin
        rem_q <= rem_q - dvs_q;
        qt_q  <= {qt_q[QuotBits-2:0], 1'b1};
      end else begin
        qt_q  <= {qt_q[QuotBits-2:0], 1'b0};
      end
      dvs_q <= dvs_q >> 1;
    end
    if (cmd_i.root_init) begin
      rt_rem_q <= qt_q;
      rt_res_q <= '0;
      rt_bit_q <= RootW'(1) << (QuotBits - 1);
    end else if (cmd_i.root_step) begin
      if ({1'b0, rt_rem_q} >= trial_c) begin
        rt_rem_q <= QuotBits'({1'b0, rt_rem_q} - trial_c);
        rt_res_q <= (rt_res_q >> 1) + rt_bit_q;
      end else begin
        rt_res_q <= rt_res_q >> 1;
      end
      rt_bit_q <= rt_bit_q >> 2;
    end
    if (cmd_i.finish) begin
      out_q.last_result <= idx_last_c;
      out_q.degenerate  <= degen_q;
      if (degen_q) begin
        out_q.zscore    <= '0;
        out_q.saturated <= 1'b0;
      end else if (!neg_q) begin
        if (big_q || (k_c > ZMaxMag)) begin
          out_q.zscore    <= ZW'(ZMaxMag);
          out_q.saturated <= 1'b1;
        end else begin
          out_q.zscore    <= k_c[ZW-1:0];
          out_q.saturated <= 1'b0;
        end
      end else begin
        if (big_q || (k_c > ZMinMag)) begin
          out_q.zscore    <= ZW'(ZMinMag);
          out_q.saturated <= 1'b1;
        end else begin
          out_q.zscore    <= kneg_c[ZW-1:0];
          out_q.saturated <= 1'b0;
        end
      end
    end
  end

  assign status_o.degen    = degen_q;
  assign status_o.idx_last = idx_last_c;
  assign out_item_o        = out_q;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import czs_pkg::*;

  localparam int Rows    = DefMaxRows;
  localparam int RootSh  = 2 * DefFractionBits;
  localparam int NoIdleLo = 3000;
  localparam int NoIdleHi = 9000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  column_zscore_standardizer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // predictor copy of the column state
  logic signed [SampleW-1:0] col_store [Rows];
  int unsigned  col_count = 0;
  longint       col_sum = 0;
  longint       col_sqsum = 0;

  in_item_t  pending_samples [$];
  out_item_t expected_z [$];

  int unsigned cycle_cnt;
  int unsigned err_cnt = 0;
  int unsigned col_total = 0;
  int unsigned z_seen = 0;
  int unsigned degen_seen = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // standardize one stored column, exact integer rounding to nearest
  function automatic void standardize_column();
    longint       q;
    longint       d;
    longint       ad;
    bit           degen;
    logic [127:0] scaled;
    logic [127:0] nq;
    logic [127:0] t;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    out_item_t    r;
    q = longint'(col_count) * col_sqsum - col_sum * col_sum;
    degen = (col_count < 2) || (q <= 0);
    col_total++;
    for (int i = 0; i < col_count; i++) begin
      r = '0;
      r.last_result = (i + 1 == col_count);
      r.degenerate  = degen;
      if (!degen) begin
        d  = longint'(col_count) * longint'(col_store[i]) - col_sum;
        ad = (d < 0) ? -d : d;
        scaled = (128'(ad) * 128'(ad) * 128'(4) * 128'(col_count - 1)) << RootSh;
        nq = 128'(col_count) * 128'(q);
        lo = 0;
        hi = 32769;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          t = 128'(2 * mid - 1);
          if (t * t * nq <= scaled) lo = mid;
          else hi = mid - 1;
        end
        if (d >= 0) begin
          if (lo > 32767) begin
            lo = 32767;
            r.saturated = 1'b1;
          end
          r.zscore = lo[15:0];
        end else begin
          if (lo > 32768) begin
            lo = 32768;
            r.saturated = 1'b1;
          end
          r.zscore = 16'(0 - lo);
        end
      end
      expected_z.push_back(r);
    end
    col_count = 0;
    col_sum   = 0;
    col_sqsum = 0;
  endfunction

  // accumulate one accepted sample, samples past the store depth are dropped
  function automatic void take_sample(in_item_t it);
    if (col_count < Rows) begin
      col_store[col_count] = it.sample_value;
      col_count++;
      col_sum   += longint'(it.sample_value);
      col_sqsum += longint'(it.sample_value) * longint'(it.sample_value);
    end
    if (it.last_sample) standardize_column();
  endfunction

  function automatic bit idle_roll();
    if (cycle_cnt >= NoIdleLo && cycle_cnt < NoIdleHi) return 1'b0;
    return ($urandom_range(99) < 12);
  endfunction

  // queue one column; kind picks the value spread
  function automatic void queue_column(int len, int kind);
    in_item_t it;
    logic signed [SampleW-1:0] base;
    base = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: it.sample_value = 16'($urandom);
        1: it.sample_value = 16'($urandom_range(40)) - 16'sd20;
        2: it.sample_value = base;
        default: it.sample_value = base + 16'($urandom_range(7));
      endcase
      it.last_sample = (i == len - 1);
      pending_samples.push_back(it);
    end
  endfunction

  function automatic void queue_fixed(logic signed [SampleW-1:0] v, bit last);
    in_item_t it;
    it.sample_value = v;
    it.last_sample  = last;
    pending_samples.push_back(it);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      cycle_cnt  <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (in_valid_i && !in_stall_o) take_sample(in_item_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_samples.size() > 0 && !idle_roll()) begin
          in_valid_i <= 1'b1;
          in_item_i  <= pending_samples.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= idle_roll();
      if (out_valid_o && !out_stall_i) begin
        z_seen++;
        if (out_item_o.degenerate) degen_seen++;
        if (expected_z.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %p", $time, out_item_o);
          err_cnt++;
        end else if (out_item_o !== expected_z[0]) begin
          $display("%0t: mismatch, expected %p actual %p", $time, expected_z[0],
                   out_item_o);
          err_cnt++;
          void'(expected_z.pop_front());
        end else begin
          void'(expected_z.pop_front());
        end
      end
    end
  end

  initial begin
    int len;
    int k;
    rst_ni     = 1'b0;

    // directed: single sample, zero spread, field extremes, one outlier
    queue_fixed(16'sh7fff, 1'b1);
    queue_fixed(-16'sd5, 1'b0);
    queue_fixed(-16'sd5, 1'b0);
    queue_fixed(-16'sd5, 1'b1);
    queue_fixed(16'sh8000, 1'b0);
    queue_fixed(16'sh7fff, 1'b1);
    queue_fixed(16'sh8000, 1'b0);
    queue_fixed(16'sh8000, 1'b0);
    queue_fixed(16'sh7fff, 1'b0);
    queue_fixed(16'sd0, 1'b1);
    queue_fixed(16'sd1, 1'b0);
    queue_fixed(16'sd2, 1'b0);
    queue_fixed(16'sd3, 1'b1);
    // overlong column: the outlier leads, extra samples are dropped
    queue_fixed(16'sh7fff, 1'b0);
    for (int i = 0; i < 68; i++) queue_fixed(16'sh8000, i == 67);

    // random columns, mostly short
    while (pending_samples.size() < 410) begin
      k = $urandom_range(99);
      if (k < 4) len = 1;
      else if (k < 8) len = $urandom_range(70, 60);
      else len = $urandom_range(12, 2);
      queue_column(len, $urandom_range(9) < 6 ? 0 : $urandom_range(3));
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_samples.size() == 0 && !in_valid_i);
    wait (expected_z.size() == 0);
    repeat (200) @(posedge clk_i);

    $display("covered %0d columns, %0d results checked, %0d of them degenerate",
             col_total, z_seen, degen_seen);
    if (err_cnt == 0 && expected_z.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
rtl/czs_pkg.sv
rtl/czs_ctrl.sv
rtl/czs_datapath.sv
rtl/column_zscore_standardizer.sv
dv/testbench.sv
